// ----- rtl/idc_pkg.sv -----
// ----------------------------------------------------------------------------
// idc_pkg: shared types and constants of the infusion dose controller
// Holds command codes, status codes, field widths and the request record.
// ----------------------------------------------------------------------------
package idc_pkg;

  localparam int NAME_BYTES      = 32;
  localparam int VOLUME_DIGITS   = 4;
  localparam int DURATION_DIGITS = 8;
  localparam int NAME_IDX_W      = $clog2(NAME_BYTES);
  localparam int CNT_W           = $clog2(NAME_BYTES + 1);

  localparam int VOL_W = 14;
  localparam int DUR_W = 27;
  localparam int PROD_W = VOL_W + 32;

  localparam logic [VOL_W-1:0] VOL_MAX = '1;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;

  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_MODIFY = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_TICK   = 3'd4;

  localparam logic [3:0] ST_CREATED  = 4'd0;
  localparam logic [3:0] ST_MODIFIED = 4'd1;
  localparam logic [3:0] ST_DELETED  = 4'd2;
  localparam logic [3:0] ST_NO_MATCH = 4'd3;
  localparam logic [3:0] ST_BAD_MODE = 4'd4;
  localparam logic [3:0] ST_IGNORED  = 4'd5;
  localparam logic [3:0] ST_UPDATED  = 4'd6;
  localparam logic [3:0] ST_ENDED    = 4'd7;
  localparam logic [3:0] ST_IDLE     = 4'd8;

  // Operation handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_CREATE,
    OP_MODIFY,
    OP_DELETE,
    OP_BAD_MODE,
    OP_IGNORED,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             name_differs;
    logic [VOL_W-1:0] volume;
    logic [DUR_W-1:0] duration;
    logic [31:0]      now;
  } req_t;

  typedef struct packed {
    logic [3:0]       status;
    logic             running;
    logic [VOL_W-1:0] volume;
    logic [DUR_W-1:0] time_left;
  } res_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

// ----- rtl/idc_fifo.sv -----
// ----------------------------------------------------------------------------
// idc_fifo: two-entry request queue between front end and back end
// Lets the parser accept bytes while the back end still holds its last result.
// ----------------------------------------------------------------------------
module idc_fifo import idc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t wdata,
  output logic full,
  input  logic pop,
  output req_t rdata,
  output logic empty
);

  req_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        mem[wptr] <= wdata;
        wptr      <= ~wptr;
      end
      if (pop && !empty) rptr <= ~rptr;
      count <= count + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule

// ----- rtl/idc_front.sv -----
// ----------------------------------------------------------------------------
// idc_front: packet parser
// Parses name, volume and duration bytes, keeps the stored name and the
// running flag, and issues one request per packet end or tick.
// ----------------------------------------------------------------------------
module idc_front import idc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [2:0]       command,
  input  logic [7:0]       data_byte,
  input  logic             packet_end,
  input  logic [31:0]      now_seconds,
  output logic             busy,
  output logic             req_valid,
  output req_t             req,
  input  logic             q_full,
  input  logic             run_set,
  input  logic             run_clear,
  input  logic             done
);

  typedef enum logic [1:0] {S_IDLE, S_CLEAR, S_PAD, S_WAIT} state_t;

  state_t                state;
  logic [1:0]            field_position;
  logic [CNT_W-1:0]      char_count;
  logic                  skip_next;
  logic                  digits_done;
  logic                  name_differs;
  logic [VOL_W-1:0]      parsed_volume;
  logic [DUR_W-1:0]      parsed_duration;
  logic [7:0]            stored_name [NAME_BYTES];
  logic [NAME_IDX_W-1:0] sweep;
  logic [NAME_IDX_W-1:0] pad_end;
  logic                  ender;
  logic                  dose_running;
  req_t                  pend;
  logic                  pend_valid;
  logic                  fin_seen;
  logic                  fin_clear;

  // Combinational decode of the current byte.
  logic                  is_tick;
  logic                  create;
  logic [NAME_IDX_W-1:0] cidx;
  logic [7:0]            cur;
  logic [17:0]           vol_acc;
  logic [30:0]           dur_acc;
  logic [VOL_W-1:0]      vol_new;
  logic [DUR_W-1:0]      dur_new;

  assign is_tick = (command == CMD_TICK);
  assign create  = (command == CMD_CREATE);
  assign cidx    = char_count[NAME_IDX_W-1:0];
  assign cur     = stored_name[cidx];
  assign vol_acc = 18'(parsed_volume) * 18'd10 + 18'(data_byte - 8'h30);
  assign dur_acc = 31'(parsed_duration) * 31'd10 + 31'(data_byte - 8'h30);
  assign vol_new = (vol_acc > 18'(VOL_MAX)) ? VOL_MAX : vol_acc[VOL_W-1:0];
  assign dur_new = (dur_acc > 31'(DUR_MAX)) ? DUR_MAX : dur_acc[DUR_W-1:0];

  assign busy      = (state != S_IDLE) || pend_valid;
  assign req_valid = pend_valid;
  assign req       = pend;

  always_ff @(posedge clk) begin
    logic                  nd;
    logic [1:0]            fp;
    logic [CNT_W-1:0]      cc;
    logic                  sk;
    logic                  dd;
    logic [VOL_W-1:0]      pv;
    logic [DUR_W-1:0]      pd;
    logic                  end_nm;
    logic [CNT_W-1:0]      nlen;
    op_t                   op;
    if (rst) begin
      state           <= S_CLEAR;
      sweep           <= '0;
      field_position  <= 2'd0;
      char_count      <= '0;
      skip_next       <= 1'b0;
      digits_done     <= 1'b0;
      name_differs    <= 1'b0;
      parsed_volume   <= '0;
      parsed_duration <= '0;
      dose_running    <= 1'b0;
      pend_valid      <= 1'b0;
      fin_seen        <= 1'b0;
      fin_clear       <= 1'b0;
    end else begin
      if (pend_valid && !q_full) pend_valid <= 1'b0;
      if (run_set) dose_running <= 1'b1;
      else if (run_clear) dose_running <= 1'b0;
      // The back end may finish while the name padding still runs, so its
      // finish pulse is held until the wait state picks it up.
      if (state == S_WAIT && (fin_seen || done || run_set || run_clear)) begin
        fin_seen  <= 1'b0;
        fin_clear <= 1'b0;
      end else begin
        if (done || run_set || run_clear) fin_seen <= 1'b1;
        if (run_clear) fin_clear <= 1'b1;
      end
      unique case (state)
        S_CLEAR: begin
          stored_name[sweep] <= 8'h00;
          sweep <= sweep + 1'b1;
          if (sweep == NAME_IDX_W'(NAME_BYTES - 1)) state <= S_IDLE;
        end
        S_PAD: begin
          if (sweep < pad_end) stored_name[sweep] <= 8'h00;
          sweep <= sweep + 1'b1;
          if (sweep >= pad_end) state <= ender ? S_WAIT : S_IDLE;
        end
        S_WAIT: begin
          if (fin_seen || done || run_set || run_clear) begin
            if (fin_clear || run_clear) begin
              // Delete or dose end wipes the stored name.
              state <= S_CLEAR;
              sweep <= '0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            nd = name_differs; fp = field_position; cc = char_count;
            sk = skip_next; dd = digits_done; pv = parsed_volume;
            pd = parsed_duration; end_nm = 1'b0; nlen = char_count;
            if (is_tick) begin
              pend.op <= OP_TICK;
              pend.now <= now_seconds;
              pend_valid <= 1'b1;
              state <= S_WAIT;
            end else if (dose_running) begin
              if (packet_end) begin
                pend.op <= OP_IGNORED;
                pend_valid <= 1'b1;
                state <= S_WAIT;
              end
            end else begin
              if (sk) begin
                sk = 1'b0;
              end else if (fp == 2'd0) begin
                if (data_byte == 8'h00) begin
                  end_nm = 1'b1;
                end else begin
                  if (cur != data_byte) nd = 1'b1;
                  if (create && cc < CNT_W'(NAME_BYTES - 1))
                    stored_name[cidx] <= data_byte;
                  cc = cc + 1'b1;
                  if (cc == CNT_W'(NAME_BYTES)) begin
                    end_nm = 1'b1; sk = 1'b1;
                  end
                end
              end else if (fp == 2'd1) begin
                if (data_byte == 8'h00) begin
                  fp = 2'd2; cc = '0; dd = 1'b0;
                end else begin
                  if (!dd) begin
                    if (is_digit(data_byte)) pv = vol_new;
                    else dd = 1'b1;
                  end
                  cc = cc + 1'b1;
                  if (cc == CNT_W'(VOLUME_DIGITS)) begin
                    fp = 2'd2; cc = '0; dd = 1'b0; sk = 1'b1;
                  end
                end
              end else if (fp == 2'd2) begin
                if (data_byte == 8'h00) begin
                  fp = 2'd3; cc = '0;
                end else begin
                  if (!dd) begin
                    if (is_digit(data_byte)) pd = dur_new;
                    else dd = 1'b1;
                  end
                  cc = cc + 1'b1;
                  if (cc == CNT_W'(DURATION_DIGITS)) begin
                    fp = 2'd3; cc = '0;
                  end
                end
              end
              if (packet_end && fp == 2'd0 && !sk) end_nm = 1'b1;
              if (end_nm) begin
                // Name length is the count before this byte's reset.
                if (cc < CNT_W'(NAME_BYTES) && data_byte == 8'h00) nlen = cc;
                else nlen = cc;
                if (nlen < CNT_W'(NAME_BYTES) &&
                    stored_name[nlen[NAME_IDX_W-1:0]] != 8'h00) nd = 1'b1;
                fp = 2'd1; cc = '0; dd = 1'b0;
              end
              if (packet_end) begin
                priority case (command)
                  CMD_CREATE: op = OP_CREATE;
                  CMD_MODIFY: op = OP_MODIFY;
                  CMD_DELETE: op = OP_DELETE;
                  default:    op = OP_BAD_MODE;
                endcase
                pend.op           <= op;
                pend.name_differs <= nd;
                pend.volume       <= pv;
                pend.duration     <= pd;
                pend.now          <= now_seconds;
                pend_valid        <= 1'b1;
                field_position <= 2'd0; char_count <= '0; skip_next <= 1'b0;
                digits_done <= 1'b0; name_differs <= 1'b0;
                parsed_volume <= '0; parsed_duration <= '0;
              end else begin
                field_position <= fp; char_count <= cc; skip_next <= sk;
                digits_done <= dd; name_differs <= nd;
                parsed_volume <= pv; parsed_duration <= pd;
              end
              ender <= packet_end;
              if (end_nm && create && nlen < CNT_W'(NAME_BYTES - 1)) begin
                sweep   <= nlen[NAME_IDX_W-1:0];
                pad_end <= NAME_IDX_W'(NAME_BYTES - 1);
                state   <= S_PAD;
              end else if (packet_end) begin
                state <= S_WAIT;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/idc_back.sv -----
// ----------------------------------------------------------------------------
// idc_back: dose engine
// Executes requests, holds the dose registers and runs a bit-serial divider
// for the remaining-volume update on a tick that updates a running dose.
// ----------------------------------------------------------------------------
module idc_back import idc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  req_t q_data,
  output logic q_pop,
  output logic res_valid,
  output res_t res,
  input  logic res_ready,
  output logic run_set,
  output logic run_clear,
  output logic done
);

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_OUT} state_t;

  state_t              state;
  logic [3:0]          res_status;
  logic [VOL_W-1:0]    initial_volume;
  logic [VOL_W-1:0]    volume_left;
  logic [DUR_W-1:0]    initial_duration;
  logic [DUR_W-1:0]    duration_left;
  logic [31:0]         start_time;
  logic                dose_running;
  logic [31:0]         elapsed;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   quo;
  logic [DUR_W:0]      rem;
  logic [5:0]          bitn;
  logic [DUR_W+1:0]    trial;

  assign q_pop = (state == B_IDLE) && !q_empty;
  assign trial = {rem, prod[PROD_W-1]} - {2'b0, initial_duration};

  always_ff @(posedge clk) begin
    logic [31:0] el;
    if (rst) begin
      state            <= B_IDLE;
      initial_volume   <= '0;
      volume_left      <= '0;
      initial_duration <= '0;
      duration_left    <= '0;
      start_time       <= '0;
      dose_running     <= 1'b0;
      res_valid        <= 1'b0;
      run_set          <= 1'b0;
      run_clear        <= 1'b0;
      done             <= 1'b0;
    end else begin
      run_set   <= 1'b0;
      run_clear <= 1'b0;
      done      <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            state <= B_OUT;
            res_valid <= 1'b1;
            unique case (q_data.op)
              OP_CREATE, OP_MODIFY: begin
                if (q_data.op == OP_MODIFY && q_data.name_differs) begin
                  res_status <= ST_NO_MATCH;
                  done <= 1'b1;
                end else begin
                  res_status <= (q_data.op == OP_CREATE) ? ST_CREATED : ST_MODIFIED;
                  initial_volume <= q_data.volume;
                  volume_left <= q_data.volume;
                  initial_duration <= q_data.duration;
                  duration_left <= q_data.duration;
                  start_time <= q_data.now;
                  dose_running <= (q_data.volume != '0) && (q_data.duration != '0);
                  if ((q_data.volume != '0) && (q_data.duration != '0)) run_set <= 1'b1;
                  else done <= 1'b1;
                end
              end
              OP_DELETE: begin
                if (q_data.name_differs) begin
                  res_status <= ST_NO_MATCH;
                  done <= 1'b1;
                end else begin
                  res_status <= ST_DELETED;
                  initial_volume <= '0; volume_left <= '0;
                  initial_duration <= '0; duration_left <= '0;
                  start_time <= '0; dose_running <= 1'b0;
                  run_clear <= 1'b1;
                end
              end
              OP_BAD_MODE: begin
                res_status <= ST_BAD_MODE;
                done <= 1'b1;
              end
              OP_IGNORED: begin
                res_status <= ST_IGNORED;
                done <= 1'b1;
              end
              OP_TICK: begin
                el = q_data.now - start_time;
                if (!dose_running) begin
                  res_status <= ST_IDLE;
                  done <= 1'b1;
                end else if (el >= 32'(initial_duration)) begin
                  res_status <= ST_ENDED;
                  initial_volume <= '0; volume_left <= '0;
                  initial_duration <= '0; duration_left <= '0;
                  start_time <= '0; dose_running <= 1'b0;
                  run_clear <= 1'b1;
                end else begin
                  res_valid <= 1'b0;
                  elapsed <= el;
                  state <= B_MUL;
                end
              end
              default: begin
                res_status <= ST_BAD_MODE;
                done <= 1'b1;
              end
            endcase
          end
        end
        B_MUL: begin
          prod  <= PROD_W'(initial_volume) * PROD_W'(elapsed);
          quo   <= '0;
          rem   <= '0;
          bitn  <= 6'(PROD_W - 1);
          state <= B_DIV;
        end
        B_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (!trial[DUR_W+1]) rem <= trial[DUR_W:0];
          else rem <= {rem[DUR_W-1:0], prod[PROD_W-1]};
          quo  <= {quo[PROD_W-2:0], !trial[DUR_W+1]};
          prod <= {prod[PROD_W-2:0], 1'b0};
          bitn <= bitn - 1'b1;
          if (bitn == 6'd0) begin
            volume_left <= initial_volume
                         - VOL_W'({quo[PROD_W-2:0], !trial[DUR_W+1]});
            duration_left <= initial_duration - elapsed[DUR_W-1:0];
            res_status <= ST_UPDATED;
            res_valid <= 1'b1;
            done <= 1'b1;
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign res = '{status: res_status, running: dose_running,
                 volume: volume_left, time_left: duration_left};

endmodule

// ----- rtl/infusion_dose_controller.sv -----
// ----------------------------------------------------------------------------
// infusion_dose_controller: infusion dose command parser and dose timer
// Parses command packets, stores a dose and tracks its progress on ticks.
// ----------------------------------------------------------------------------
// Usage: requests enter on the push/full channel, one packet byte or one
// time tick per request. A packet byte that is not the last of its packet
// gives no result; the last byte of a packet and every tick give one result
// on the pop/empty channel, which holds it until it is popped.
// The front end parses bytes and hands one operation per packet end or tick
// to the back end through a two-entry queue. A plain packet byte leaves the
// parser idle for the next byte. A create byte that ends the name field adds
// a padding sweep that zeroes the rest of the stored name. A packet end is
// registered in the front end, passes the queue and gives its result from
// the back end's result register. A tick that updates a running dose gives
// its result after the multiply step and the 46-step bit-serial divider of
// the back end, one quotient bit per cycle. After either, the next request
// is taken once the front end sees the back end finish. Delete and dose end
// add a sweep that zeroes the stored name; after reset full stays high while
// the stored name is swept to zero. A stalled receiver holds the result and,
// through the back end, stops the parser after its next packet end or tick.
// ----------------------------------------------------------------------------
module infusion_dose_controller import idc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [2:0]              command,
  input  logic [7:0]              data_byte,
  input  logic                    packet_end,
  input  logic [31:0]             now_seconds,
  output logic                    empty,
  input  logic                    pop,
  output logic [3:0]              status,
  output logic                    running,
  output logic [VOL_W-1:0]        remaining_volume,
  output logic [DUR_W-1:0]        remaining_time
);

  logic busy;
  logic fr_valid;
  req_t fr_req;
  logic q_full;
  logic q_empty;
  req_t q_data;
  logic q_pop;
  logic res_valid;
  res_t res;
  logic run_set;
  logic run_clear;
  logic done;
  logic waiting;

  // The front end waits for the back end to finish each operation, since the
  // parser depends on the running flag and the stored name it leaves.
  always_ff @(posedge clk) begin
    if (rst) waiting <= 1'b0;
    else if (fr_valid && !q_full) waiting <= 1'b1;
    else if (done || run_set || run_clear) waiting <= 1'b0;
  end

  assign full = busy || waiting;

  idc_front u_front (
    .clk, .rst,
    .in_valid (push && !full),
    .command, .data_byte, .packet_end, .now_seconds,
    .busy,
    .req_valid (fr_valid),
    .req       (fr_req),
    .q_full,
    .run_set, .run_clear, .done
  );

  idc_fifo u_fifo (
    .clk, .rst,
    .push  (fr_valid),
    .wdata (fr_req),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  idc_back u_back (
    .clk, .rst,
    .q_empty, .q_data, .q_pop,
    .res_valid, .res,
    .res_ready (pop),
    .run_set, .run_clear, .done
  );

  assign empty            = !res_valid;
  assign status           = res.status;
  assign running          = res.running;
  assign remaining_volume = res.volume;
  assign remaining_time   = res.time_left;

endmodule
